// ----- sv/hex_ascii_frame_encoder_macros.svh -----
// Assertion macros used by the frame encoder checker
`ifndef HEX_ASCII_FRAME_ENCODER_MACROS_SVH
`define HEX_ASCII_FRAME_ENCODER_MACROS_SVH

// implication checked out of reset
`define HAFE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hafe assertion failed");

// condition in the cycle after the antecedent, checked out of reset
`define HAFE_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hafe assertion failed");

// condition in the cycle after reset is seen low
`define HAFE_ASSERT_RST(name, clk, rst_n, cons) \
    name: assert property (@(posedge clk) !rst_n |=> (cons)) \
        else $error("hafe reset assertion failed");

`endif

// ----- sv/hafe_pkg.sv -----
// Package: types, constants and helpers of the hex ASCII frame encoder
package hafe_pkg;

    localparam logic [7:0] HEAD_MARK   = 8'hAA;
    localparam logic [7:0] TAIL_MARK   = 8'h55;
    localparam int         MARK_COUNT  = 3;
    localparam int         MARK_CNT_W  = $clog2(MARK_COUNT);
    localparam logic [MARK_CNT_W-1:0] MARK_LAST = MARK_CNT_W'(MARK_COUNT - 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // classified request handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] chk;
        logic       open;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_entry_t;

    typedef enum logic [2:0] {
        PH_HEAD,
        PH_DATA_HI,
        PH_DATA_LO,
        PH_CHK_HI,
        PH_CHK_LO,
        PH_TAIL
    } phase_t;

    function automatic logic [7:0] nibble_char(input logic [3:0] v);
        logic [7:0] w;
        w = {4'h0, v};
        if (v <= 4'd9)
            return 8'h30 + w;
        else
            return 8'h41 + (w - 8'h0A);
    endfunction

endpackage

// ----- sv/hafe_cmd_if.sv -----
// Interface: payload byte request channel
interface hafe_cmd_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- sv/hafe_char_if.sv -----
// Interface: output character channel
interface hafe_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       run_last;

    modport source (output valid, output out_char, output run_last, input ready);
    modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

// ----- sv/hafe_front.sv -----
// Front end: takes payload requests, tracks frame state and checksum, classifies
module hafe_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [7:0]      in_data,
    input  logic            in_last,
    output logic            in_ready,
    input  logic            q_full,
    output hafe_pkg::q_entry_t push
);
    import hafe_pkg::*;

    logic       in_frame_reg, in_frame_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] sum_new;
    logic       take;

    assign in_ready = !q_full;
    assign take     = in_valid && !q_full;

    // a new frame starts its sum from zero
    assign sum_new = (in_frame_reg ? sum_reg : 8'h00) + in_data;

    always_comb
    begin
        push.valid    = take;
        push.cmd.data = in_data;
        push.cmd.chk  = ~sum_new;
        push.cmd.open = !in_frame_reg;
        push.cmd.last = in_last;
    end

    always_comb
    begin
        in_frame_next = in_frame_reg;
        sum_next      = sum_reg;
        if (take)
        begin
            in_frame_next = !in_last;
            sum_next      = in_last ? 8'h00 : sum_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            sum_reg      <= 8'h00;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            sum_reg      <= sum_next;
        end
    end

endmodule

// ----- sv/hafe_queue.sv -----
// Short request queue between front and back end
module hafe_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  hafe_pkg::q_entry_t push,
    output logic               full,
    output hafe_pkg::q_entry_t head,
    input  logic               pop
);
    import hafe_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = slot_reg[rd_ptr_reg];

    assign do_push = push.valid && !full;
    assign do_pop  = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push.cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- sv/hafe_back.sv -----
// Back end: steps through the characters of each request into an output register
module hafe_back (
    input  logic               clk,
    input  logic               rst_n,
    input  hafe_pkg::q_entry_t head,
    output logic               pop,
    output logic               out_valid,
    output logic [7:0]         out_char,
    output logic               out_last,
    input  logic               out_ready
);
    import hafe_pkg::*;

    cmd_t                  cur_reg;
    logic                  busy_reg, busy_next;
    phase_t                phase_reg, phase_next;
    logic [MARK_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  ovalid_reg;
    logic [7:0]            ochar_reg;
    logic                  olast_reg;

    logic                  adv;
    logic                  final_char;
    logic [7:0]            char_sel;

    assign adv = busy_reg && (!ovalid_reg || out_ready);
    // next request loads in the same cycle the previous one issues its last char
    assign pop = head.valid && (!busy_reg || (adv && final_char));

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        if (pop)
        begin
            busy_next  = 1'b1;
            phase_next = head.cmd.open ? PH_HEAD : PH_DATA_HI;
            cnt_next   = '0;
        end
        else if (adv && final_char)
        begin
            busy_next = 1'b0;
        end
        else if (adv)
        begin
            case (phase_reg)
                PH_HEAD:
                begin
                    if (cnt_reg == MARK_LAST)
                    begin
                        phase_next = PH_DATA_HI;
                        cnt_next   = '0;
                    end
                    else
                        cnt_next = cnt_reg + 1'b1;
                end
                PH_DATA_HI: phase_next = PH_DATA_LO;
                PH_DATA_LO: phase_next = PH_CHK_HI;
                PH_CHK_HI:  phase_next = PH_CHK_LO;
                PH_CHK_LO:
                begin
                    phase_next = PH_TAIL;
                    cnt_next   = '0;
                end
                PH_TAIL:    cnt_next = cnt_reg + 1'b1;
                default:    phase_next = PH_HEAD;
            endcase
        end
    end

    // outputs of the current step
    always_comb
    begin
        char_sel   = HEAD_MARK;
        final_char = 1'b0;
        case (phase_reg)
            PH_HEAD:    char_sel = HEAD_MARK;
            PH_DATA_HI: char_sel = nibble_char(cur_reg.data[7:4]);
            PH_DATA_LO:
            begin
                char_sel   = nibble_char(cur_reg.data[3:0]);
                final_char = !cur_reg.last;
            end
            PH_CHK_HI:  char_sel = nibble_char(cur_reg.chk[7:4]);
            PH_CHK_LO:  char_sel = nibble_char(cur_reg.chk[3:0]);
            PH_TAIL:
            begin
                char_sel   = TAIL_MARK;
                final_char = (cnt_reg == MARK_LAST);
            end
            default:    char_sel = HEAD_MARK;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head.cmd;
        if (adv)
        begin
            ochar_reg <= char_sel;
            olast_reg <= final_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            phase_reg  <= PH_HEAD;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            if (adv)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_char  = ochar_reg;
    assign out_last  = olast_reg;

endmodule

// ----- sv/hex_ascii_frame_encoder.sv -----
// Top level of the hex ASCII frame encoder
//
//   channel  dir  handshake      payload
//   cmd      in   valid/ready    data_byte[7:0], last_byte
//   chars    out  valid/ready    out_char[7:0], run_last
//
// Each request yields 2 characters, 5 when it opens a frame, 7 when it closes one,
// 10 when it does both; the back end issues one character per cycle while the
// sink is ready. A 2-entry queue lets the front take requests while the back
// end or a stalled sink is busy. Reset clears frame state, queue and output
// valid; no clearing pass is needed.
module hex_ascii_frame_encoder (
    input logic      clk,
    input logic      rst_n,
    hafe_cmd_if.sink   cmd,
    hafe_char_if.source chars
);
    import hafe_pkg::*;

    q_entry_t push;
    q_entry_t head;
    logic     q_full;
    logic     pop;

    hafe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_data  (cmd.data_byte),
        .in_last  (cmd.last_byte),
        .in_ready (cmd.ready),
        .q_full   (q_full),
        .push     (push)
    );

    hafe_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    hafe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (chars.valid),
        .out_char  (chars.out_char),
        .out_last  (chars.run_last),
        .out_ready (chars.ready)
    );

endmodule

// ----- sv/hafe_checker.sv -----
// Port-level checker for the hex ASCII frame encoder, bound to the top level
`include "hex_ascii_frame_encoder_macros.svh"

module hafe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       run_last
);
    import hafe_pkg::*;

    logic       is_digit;
    logic       is_mark;
    logic       stalled;
    logic [8:0] out_pay;

    assign is_digit = ((out_char >= 8'h30) && (out_char <= 8'h39)) ||
                      ((out_char >= 8'h41) && (out_char <= 8'h46));
    assign is_mark  = (out_char == HEAD_MARK) || (out_char == TAIL_MARK);
    assign stalled  = out_valid && !out_ready;
    assign out_pay  = {run_last, out_char};

    `HAFE_ASSERT_RST(a_idle_after_reset, clk, rst_n, !out_valid)
    `HAFE_ASSERT_IMP(a_char_legal, clk, rst_n, out_valid, is_digit || is_mark)
    `HAFE_ASSERT_IMP(a_last_not_head, clk, rst_n, out_valid && run_last, out_char != HEAD_MARK)
    `HAFE_ASSERT_NXT(a_stall_holds, clk, rst_n, stalled, out_valid && $stable(out_pay))

endmodule

bind hex_ascii_frame_encoder hafe_checker u_hafe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (chars.valid),
    .out_ready (chars.ready),
    .out_char  (chars.out_char),
    .run_last  (chars.run_last)
);
